FILE: hdl/wila_pkg.sv
//------------------------------------------------------------------------------
// wila_pkg
// Shared types and constants for the weighted interest lookup accumulator.
//------------------------------------------------------------------------------
`default_nettype none

package wila_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_MAP   = 1'b1;

   localparam logic signed [15:0] MIN_WEIGHT = 16'sd5;

   localparam logic signed [31:0] RST_MIN_VALUE     = 32'sd0;
   localparam logic [31:0]        RST_INVERSE_STEP  = 32'd65536;
   localparam logic signed [15:0] RST_MAP_WEIGHT    = 16'sd4096;
   localparam logic [14:0]        RST_MIN_VALID     = 15'd0;
   localparam logic signed [31:0] RST_MISSING_VALUE = -32'sd655294464;
   localparam logic               RST_MAP_ENABLE    = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_VALUE     = 3'd0,
      CSR_INVERSE_STEP  = 3'd1,
      CSR_MAP_WEIGHT    = 3'd2,
      CSR_MIN_VALID     = 3'd3,
      CSR_MISSING_VALUE = 3'd4,
      CSR_MAP_ENABLE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               func;
      logic               first;
      logic signed [31:0] sample;
      logic [9:0]         entry_index;
      logic signed [15:0] entry_data;
   } req_type;

   typedef struct packed {
      logic signed [15:0] weighted_interest;
      logic signed [15:0] weight_used;
      logic               counted;
      logic signed [31:0] sum_interest_out;
      logic signed [31:0] sum_weight_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] min_value;
      logic [31:0]        inverse_step;
      logic signed [15:0] map_weight;
      logic [14:0]        min_valid_interest;
      logic signed [31:0] missing_value;
      logic               map_enable;
   } cfg_type;

   typedef struct packed {
      logic               first;
      logic               active;
      logic signed [15:0] interest;
   } q_item_type;

endpackage

`default_nettype wire

FILE: hdl/wila_ram.sv
//------------------------------------------------------------------------------
// wila_ram
// Generic single write port, single read port RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none

module wila_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/wila_front.sv
//------------------------------------------------------------------------------
// wila_front
// Front pipeline: missing/enable check, index multiply, clamp, table access.
//------------------------------------------------------------------------------
`default_nettype none

module wila_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  wila_pkg::req_type          in_req,
   input  wila_pkg::cfg_type          cfg,
   output logic                       ram_we,
   output logic [wila_pkg::ADDR_W-1:0] ram_waddr,
   output logic [15:0]                ram_wdata,
   output logic                       ram_re,
   output logic [wila_pkg::ADDR_W-1:0] ram_raddr,
   input  logic [15:0]                ram_rdata,
   output logic                       q_push,
   output wila_pkg::q_item_type       q_item,
   output logic [1:0]                 inflight
);
   import wila_pkg::*;

   typedef struct packed {
      logic        func;
      logic        first;
      logic        active;
      logic        pos;
      logic [31:0] diff;
      logic [9:0]  index;
      logic [15:0] data;
   } s1_type;

   typedef struct packed {
      logic        func;
      logic        first;
      logic        active;
      logic        pos;
      logic [63:0] prod;
      logic [9:0]  index;
      logic [15:0] data;
   } s2_type;

   typedef struct packed {
      logic first;
      logic active;
   } s3_type;

   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic   s2_valid_in, s3_valid_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   logic signed [32:0] diff_full;
   logic [32:0]        idx_raw;
   logic               in_range;

   always_comb begin
      diff_full    = {in_req.sample[31], in_req.sample} - {cfg.min_value[31], cfg.min_value};
      s1_in.func   = in_req.func;
      s1_in.first  = in_req.first;
      s1_in.active = cfg.map_enable && (in_req.sample != cfg.missing_value);
      s1_in.pos    = !diff_full[32] && (diff_full != 33'sd0);
      s1_in.diff   = diff_full[31:0];
      s1_in.index  = in_req.entry_index;
      s1_in.data   = in_req.entry_data;
   end

   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_in.func   = s1_ff.func;
      s2_in.first  = s1_ff.first;
      s2_in.active = s1_ff.active;
      s2_in.pos    = s1_ff.pos;
      s2_in.prod   = s1_ff.diff * cfg.inverse_step;
      s2_in.index  = s1_ff.index;
      s2_in.data   = s1_ff.data;
   end

   // round to nearest: upper word plus the bit below it
   always_comb begin
      idx_raw  = {1'b0, s2_ff.prod[63:32]} + {32'b0, s2_ff.prod[31]};
      in_range = 32'(s2_ff.index) < 32'(TABLE_DEPTH);
      if (!s2_ff.pos) begin
         ram_raddr = '0;
      end else if (idx_raw > 33'(TABLE_DEPTH - 1)) begin
         ram_raddr = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         ram_raddr = idx_raw[ADDR_W-1:0];
      end
      ram_re       = s2_valid_ff && (s2_ff.func == FUNC_MAP);
      ram_we       = s2_valid_ff && (s2_ff.func == FUNC_WRITE) && in_range;
      ram_waddr    = ADDR_W'(s2_ff.index);
      ram_wdata    = s2_ff.data;
      s3_valid_in  = ram_re;
      s3_in.first  = s2_ff.first;
      s3_in.active = s2_ff.active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   assign q_push          = s3_valid_ff;
   assign q_item.first    = s3_ff.first;
   assign q_item.active   = s3_ff.active;
   assign q_item.interest = ram_rdata;
   assign inflight        = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

endmodule

`default_nettype wire

FILE: hdl/wila_queue.sv
//------------------------------------------------------------------------------
// wila_queue
// Short queue of classified lookups between front and back.
//------------------------------------------------------------------------------
`default_nettype none

module wila_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  wila_pkg::q_item_type       item_in,
   input  logic                       pop,
   output wila_pkg::q_item_type       head,
   output logic                       head_valid,
   output logic [wila_pkg::QCNT_W-1:0] count
);
   import wila_pkg::*;

   q_item_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

endmodule

`default_nettype wire

FILE: hdl/wila_back.sv
//------------------------------------------------------------------------------
// wila_back
// Back end: threshold test, saturating accumulation and result register.
//------------------------------------------------------------------------------
`default_nettype none

module wila_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  wila_pkg::q_item_type q_head,
   output logic                 q_pop,
   input  wila_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   output wila_pkg::rsp_type    rsp,
   input  logic                 rsp_pop
);
   import wila_pkg::*;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return s[31:0];
   endfunction

   logic               take;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic signed [31:0] sum_i_ff, sum_i_in;
   logic signed [31:0] sum_w_ff, sum_w_in;
   logic signed [31:0] base_i, base_w;
   logic signed [15:0] interest, wt;
   logic signed [16:0] i_ext, t_ext;
   logic               counted;

   always_comb begin
      take     = q_valid && (!rsp_valid_ff || rsp_pop);
      interest = q_head.active ? q_head.interest : 16'sd0;
      wt       = q_head.active ? cfg.map_weight : 16'sd0;
      i_ext    = {interest[15], interest};
      t_ext    = {2'b00, cfg.min_valid_interest};
      counted  = q_head.active
                 && ((cfg.map_weight >= MIN_WEIGHT) || (cfg.map_weight <= -MIN_WEIGHT))
                 && ((i_ext > t_ext) || (i_ext < -t_ext));
      base_i   = q_head.first ? 32'sd0 : sum_i_ff;
      base_w   = q_head.first ? 32'sd0 : sum_w_ff;
      if (counted) begin
         sum_i_in = sat_add(base_i, {{16{interest[15]}}, interest});
         sum_w_in = sat_add(base_w, {{16{wt[15]}}, wt});
      end else begin
         sum_i_in = base_i;
         sum_w_in = base_w;
      end
      rsp_in.weighted_interest = interest;
      rsp_in.weight_used       = wt;
      rsp_in.counted           = counted;
      rsp_in.sum_interest_out  = sum_i_in;
      rsp_in.sum_weight_out    = sum_w_in;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sum_i_ff     <= '0;
         sum_w_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            sum_i_ff <= sum_i_in;
            sum_w_ff <= sum_w_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign q_pop     = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/weighted_interest_lut_accumulator.sv
//------------------------------------------------------------------------------
// weighted_interest_lut_accumulator
// Maps Q16.16 samples through a loaded interest table and accumulates the
// weighted interest and weight in saturating running sums.
//------------------------------------------------------------------------------
// Usage:
//   Requests enter on push/full/req_data. func=0 writes one table entry,
//   func=1 maps a sample and yields one result on rsp_data/empty/pop.
//   Configuration is written through csr_we/csr_index/csr_wdata while idle.
//   Path: a mapped request passes the two front stages, the table read,
//   one queue slot and the result register before it shows on rsp_data.
//   Throughput: one request per cycle while full is low; the front pipeline,
//   the queue and the accumulator each work on a different request.
//   full rises when the front pipeline plus the queue hold QUEUE_DEPTH
//   requests, so a stalled receiver backs up the queue first, then push.
//   Reset clears both sums, all valid state and the registers to defaults.
//   Table contents are undefined until written.
//------------------------------------------------------------------------------
`default_nettype none

module weighted_interest_lut_accumulator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  wila_pkg::req_type              req_data,
   output logic                           empty,
   input  logic                           pop,
   output wila_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [wila_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wila_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wila_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              accept;
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [15:0]       ram_wdata, ram_rdata;
   logic              q_push, q_pop, q_valid;
   q_item_type        q_item, q_head;
   logic [QCNT_W-1:0] q_count;
   logic [1:0]        inflight;
   logic              rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_VALUE:     cfg_in.min_value          = csr_wdata;
            CSR_INVERSE_STEP:  cfg_in.inverse_step       = csr_wdata;
            CSR_MAP_WEIGHT:    cfg_in.map_weight         = csr_wdata[15:0];
            CSR_MIN_VALID:     cfg_in.min_valid_interest = csr_wdata[14:0];
            CSR_MISSING_VALUE: cfg_in.missing_value      = csr_wdata;
            CSR_MAP_ENABLE:    cfg_in.map_enable         = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_value          <= RST_MIN_VALUE;
         cfg_ff.inverse_step       <= RST_INVERSE_STEP;
         cfg_ff.map_weight         <= RST_MAP_WEIGHT;
         cfg_ff.min_valid_interest <= RST_MIN_VALID;
         cfg_ff.missing_value      <= RST_MISSING_VALUE;
         cfg_ff.map_enable         <= RST_MAP_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full   = ({{(QCNT_W + 1 - 2){1'b0}}, inflight} + {1'b0, q_count})
                   >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept = push && !full;

   wila_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .cfg       (cfg_ff),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .q_push    (q_push),
      .q_item    (q_item),
      .inflight  (inflight)
   );

   wila_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wila_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .item_in    (q_item),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_valid),
      .count      (q_count)
   );

   wila_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .rsp_pop   (pop)
   );

   assign empty = !rsp_valid;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result visible right after reset");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)) || q_pop)
      else $error("queue overflow");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      ({{(QCNT_W + 1 - 2){1'b0}}, inflight} + {1'b0, q_count})
         <= (QCNT_W + 1)'(QUEUE_DEPTH))
      else $error("more requests in flight than queue slots");

   a_counted_weight: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.counted |-> rsp_data.weight_used != 16'sd0
         && rsp_data.weighted_interest != 16'sd0)
      else $error("counted result with zero weight or interest");

endmodule

`default_nettype wire
